[hw/rtl/cau_pkg.sv]
package cau_pkg;

  localparam int PART_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int PROD_W = 2 * PART_WIDTH;
  localparam int SUM_W  = PROD_W + 1;
  localparam int MAG_W  = PROD_W;
  localparam int DEN_W  = PROD_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int QB     = PART_WIDTH + 1;
  localparam int NW     = MAG_W + FRAC_BITS;
  localparam int CMP_W  = DEN_W + QB - FRAC_BITS + 1;
  localparam int IN_W   = ((2 + 4 * PART_WIDTH + 7) / 8) * 8;
  localparam int OUT_W  = ((2 + 2 * PART_WIDTH + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic             is_div;
    logic             dz;
    logic             neg_re;
    logic             neg_im;
    logic             ovf_re;
    logic             ovf_im;
    logic [DEN_W-1:0] den;
    logic [REM_W-1:0] r_re;
    logic [REM_W-1:0] r_im;
    logic [QB-1:0]    n_re;
    logic [QB-1:0]    n_im;
    logic [MAG_W-1:0] q_re;
    logic [MAG_W-1:0] q_im;
  } cau_cell_t;

endpackage

[hw/rtl/cau_front.sv]
module cau_front
  import cau_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  cmd_t            cmd,
  input  logic signed [PART_WIDTH-1:0] a_real,
  input  logic signed [PART_WIDTH-1:0] a_imag,
  input  logic signed [PART_WIDTH-1:0] b_real,
  input  logic signed [PART_WIDTH-1:0] b_imag,
  output logic            dn_valid,
  input  logic            dn_ready,
  output cau_cell_t       dn_data
);

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  cmd_t                          cmd1_r;
  logic signed [PROD_W-1:0]      p_rr_r, p_ii_r, p_ri_r, p_ir_r, s_br_r, s_bi_r;
  logic signed [PART_WIDTH:0]    sr_r, si_r;

  logic                          is_div2_r, dz2_r, neg_re2_r, neg_im2_r;
  logic [MAG_W-1:0]              mag_re2_r, mag_im2_r;
  logic [DEN_W-1:0]              den2_r;

  cau_cell_t                     cell_r;

  logic signed [SUM_W-1:0]       v_re, v_im;
  logic signed [PART_WIDTH:0]    ar_x, ai_x, br_x, bi_x;
  logic signed [PROD_W-1:0]      ar_w, ai_w, br_w, bi_w;
  logic                          neg_re, neg_im;
  logic [MAG_W-1:0]              mag_re, mag_im;
  logic [DEN_W-1:0]              den;
  logic [NW-1:0]                 nf_re, nf_im;
  logic [CMP_W-1:0]              lim;
  cau_cell_t                     cell_nxt;

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v3_r;
  assign dn_data  = cell_r;

  assign ar_x = (PART_WIDTH+1)'(a_real);
  assign ai_x = (PART_WIDTH+1)'(a_imag);
  assign br_x = (PART_WIDTH+1)'(b_real);
  assign bi_x = (PART_WIDTH+1)'(b_imag);

  assign ar_w = PROD_W'(a_real);
  assign ai_w = PROD_W'(a_imag);
  assign br_w = PROD_W'(b_real);
  assign bi_w = PROD_W'(b_imag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && up_valid) begin
      cmd1_r <= cmd;
      p_rr_r <= ar_w * br_w;
      p_ii_r <= ai_w * bi_w;
      p_ri_r <= ar_w * bi_w;
      p_ir_r <= ai_w * br_w;
      s_br_r <= br_w * br_w;
      s_bi_r <= bi_w * bi_w;
      if (cmd == CMD_SUB) begin
        sr_r <= ar_x - br_x;
        si_r <= ai_x - bi_x;
      end else begin
        sr_r <= ar_x + br_x;
        si_r <= ai_x + bi_x;
      end
    end
  end

  always_comb begin
    case (cmd1_r)
      CMD_MUL: begin
        v_re = SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
        v_im = SUM_W'(p_ri_r) + SUM_W'(p_ir_r);
      end
      CMD_DIV: begin
        v_re = SUM_W'(p_rr_r) + SUM_W'(p_ii_r);
        v_im = SUM_W'(p_ir_r) - SUM_W'(p_ri_r);
      end
      default: begin
        v_re = SUM_W'(sr_r);
        v_im = SUM_W'(si_r);
      end
    endcase
    neg_re = v_re[SUM_W-1];
    neg_im = v_im[SUM_W-1];
    mag_re = neg_re ? MAG_W'(-v_re) : MAG_W'(v_re);
    mag_im = neg_im ? MAG_W'(-v_im) : MAG_W'(v_im);
    if (cmd1_r == CMD_MUL) begin
      mag_re = mag_re >> FRAC_BITS;
      mag_im = mag_im >> FRAC_BITS;
    end
    den = DEN_W'($unsigned(s_br_r)) + DEN_W'($unsigned(s_bi_r));
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      is_div2_r <= (cmd1_r == CMD_DIV);
      dz2_r     <= (cmd1_r == CMD_DIV) && (den == '0);
      neg_re2_r <= neg_re;
      neg_im2_r <= neg_im;
      mag_re2_r <= mag_re;
      mag_im2_r <= mag_im;
      den2_r    <= den;
    end
  end

  always_comb begin
    nf_re = NW'(mag_re2_r) << FRAC_BITS;
    nf_im = NW'(mag_im2_r) << FRAC_BITS;
    lim   = CMP_W'(den2_r) << (QB - FRAC_BITS);
    cell_nxt.is_div = is_div2_r;
    cell_nxt.dz     = dz2_r;
    cell_nxt.neg_re = neg_re2_r;
    cell_nxt.neg_im = neg_im2_r;
    cell_nxt.ovf_re = is_div2_r && (CMP_W'(mag_re2_r) >= lim);
    cell_nxt.ovf_im = is_div2_r && (CMP_W'(mag_im2_r) >= lim);
    cell_nxt.den    = den2_r;
    cell_nxt.r_re   = REM_W'(nf_re >> QB);
    cell_nxt.r_im   = REM_W'(nf_im >> QB);
    cell_nxt.n_re   = nf_re[QB-1:0];
    cell_nxt.n_im   = nf_im[QB-1:0];
    cell_nxt.q_re   = is_div2_r ? '0 : mag_re2_r;
    cell_nxt.q_im   = is_div2_r ? '0 : mag_im2_r;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) cell_r <= cell_nxt;
  end

endmodule

[hw/rtl/cau_div_cell.sv]
module cau_div_cell
  import cau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  cau_cell_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output cau_cell_t dn_data
);

  logic      v_r;
  cau_cell_t d_r;
  cau_cell_t d_nxt;
  logic [REM_W-1:0] t_re, t_im;
  logic b_re, b_im;

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  // one restoring step per part: bring down the next dividend bit
  always_comb begin
    d_nxt = up_data;
    t_re  = {up_data.r_re[REM_W-2:0], up_data.n_re[QB-1]};
    t_im  = {up_data.r_im[REM_W-2:0], up_data.n_im[QB-1]};
    b_re  = t_re >= REM_W'(up_data.den);
    b_im  = t_im >= REM_W'(up_data.den);
    if (up_data.is_div) begin
      d_nxt.r_re = b_re ? t_re - REM_W'(up_data.den) : t_re;
      d_nxt.r_im = b_im ? t_im - REM_W'(up_data.den) : t_im;
      d_nxt.n_re = up_data.n_re << 1;
      d_nxt.n_im = up_data.n_im << 1;
      d_nxt.q_re = {up_data.q_re[MAG_W-2:0], b_re};
      d_nxt.q_im = {up_data.q_im[MAG_W-2:0], b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) d_r <= d_nxt;
  end

endmodule

[hw/rtl/cau_out.sv]
module cau_out
  import cau_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  cau_cell_t             up_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PART_WIDTH-1:0] res_real,
  output logic [PART_WIDTH-1:0] res_imag,
  output logic [1:0]            status
);

  localparam logic [MAG_W-1:0] POS_LIM = MAG_W'((64'd1 << (PART_WIDTH - 1)) - 64'd1);
  localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(64'd1 << (PART_WIDTH - 1));

  logic                  v_r;
  logic [PART_WIDTH-1:0] re_r, im_r;
  logic [1:0]            st_r;
  logic [PART_WIDTH-1:0] re_c, im_c;
  logic                  sat_re, sat_im;
  logic [MAG_W-1:0]      m_re, m_im, c_re, c_im;

  assign up_ready  = !v_r || out_ready;
  assign out_valid = v_r;
  assign res_real  = re_r;
  assign res_imag  = im_r;
  assign status    = st_r;

  always_comb begin
    m_re   = up_data.ovf_re ? '1 : up_data.q_re;
    m_im   = up_data.ovf_im ? '1 : up_data.q_im;
    sat_re = up_data.neg_re ? (m_re > NEG_LIM) : (m_re > POS_LIM);
    sat_im = up_data.neg_im ? (m_im > NEG_LIM) : (m_im > POS_LIM);
    c_re   = sat_re ? (up_data.neg_re ? NEG_LIM : POS_LIM) : m_re;
    c_im   = sat_im ? (up_data.neg_im ? NEG_LIM : POS_LIM) : m_im;
    re_c   = up_data.neg_re ? PART_WIDTH'(-c_re) : PART_WIDTH'(c_re);
    im_c   = up_data.neg_im ? PART_WIDTH'(-c_im) : PART_WIDTH'(c_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      if (up_data.dz) begin
        re_r <= '0;
        im_r <= '0;
        st_r <= ST_DZ;
      end else begin
        re_r <= re_c;
        im_r <= im_c;
        st_r <= (sat_re || sat_im) ? ST_SAT : ST_OK;
      end
    end
  end

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_DZ |-> res_real == '0 && res_imag == '0)
    else $error("divide by zero result not zero");

  a_st_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> status == ST_OK || status == ST_SAT || status == ST_DZ)
    else $error("bad status code");

  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_SAT |->
      res_real == PART_WIDTH'(POS_LIM) || res_real == PART_WIDTH'(NEG_LIM) ||
      res_imag == PART_WIDTH'(POS_LIM) || res_imag == PART_WIDTH'(NEG_LIM))
    else $error("saturated result not at a bound");

endmodule

[hw/rtl/complex_arithmetic_unit.sv]
// Complex arithmetic unit: add, subtract, multiply or divide two complex
// operands in signed Q8.8, one result per operand transfer.
// Input channel in_*: tdata carries cmd, a_real, a_imag, b_real, b_imag.
// Output channel out_*: tdata carries res_real, res_imag, status
// (0 ok, 1 saturated, 2 divide by zero; zero result on divide by zero).
// Throughput: one transfer per cycle on both sides when out_tready is high.
// Pipeline, the same for every command from input transfer to out_tvalid:
// 3 front stages (products, sign/magnitude, divider setup), a row of 17
// divider cells that each resolve one quotient bit, and the output stage
// that truncates and saturates. Non-divide items ride through the cells.
// Each stage holds its item while the next is full, so a stalled receiver
// fills the pipe from the output back; in_tready drops only when every
// stage is occupied. Reset (rst_n low, synchronous) empties the pipe;
// no other state exists.
module complex_arithmetic_unit
  import cau_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // cmd, a_real, a_imag, b_real, b_imag
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // res_real, res_imag, status
);

  localparam int A_R = 2;
  localparam int A_I = A_R + PART_WIDTH;
  localparam int B_R = A_I + PART_WIDTH;
  localparam int B_I = B_R + PART_WIDTH;

  cau_cell_t             cd   [QB+1];
  logic                  cv   [QB+1];
  logic                  crdy [QB+1];
  logic [PART_WIDTH-1:0] res_real, res_imag;
  logic [1:0]            status;

  cau_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .cmd      (cmd_t'(in_tdata[1:0])),
    .a_real   (in_tdata[A_R +: PART_WIDTH]),
    .a_imag   (in_tdata[A_I +: PART_WIDTH]),
    .b_real   (in_tdata[B_R +: PART_WIDTH]),
    .b_imag   (in_tdata[B_I +: PART_WIDTH]),
    .dn_valid (cv[0]),
    .dn_ready (crdy[0]),
    .dn_data  (cd[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_cell
    cau_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (cv[k]),
      .up_ready (crdy[k]),
      .up_data  (cd[k]),
      .dn_valid (cv[k+1]),
      .dn_ready (crdy[k+1]),
      .dn_data  (cd[k+1])
    );
  end

  cau_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (cv[QB]),
    .up_ready  (crdy[QB]),
    .up_data   (cd[QB]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_real  (res_real),
    .res_imag  (res_imag),
    .status    (status)
  );

  assign out_tdata = OUT_W'({status, res_imag, res_real});

endmodule
